// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol frequency ranking package
// Shared widths, operation codes, request and result types, and helpers.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int NUM_BINS = 127;
  localparam int COUNT_W  = 32;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int KEY_W    = COUNT_W + BIN_W;
  localparam int RANK_W   = 7;
  localparam int DIST_W   = 7;

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic [6:0] rank_index;
  } sfr_req_t;

  typedef struct packed {
    logic        found;
    logic [6:0]  symbol;
    logic [31:0] weight;
    logic [6:0]  distinct_symbols;
    logic [31:0] total_bytes;
  } sfr_rsp_t;

  // Control of the bin memory: one read port, one write port, bulk clear.
  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [BIN_W-1:0] rd_addr;
    logic             wr_en;
    logic [BIN_W-1:0] wr_addr;
  } sfr_mem_ctl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ===== rtl/symbol_frequency_sorted_ranking_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol frequency ranking
// Histogram of byte values with rank queries in ascending weight order.
// ----------------------------------------------------------------------------
// Usage:
//   A request (count, query or clear) is taken at a rising edge where start
//   is high and busy is low. Only a query gives a result: done is high for
//   exactly one cycle while result holds it; the receiver cannot stall.
//   A count of a byte below the bin count keeps busy high for one cycle
//   (read, then saturating write of the bin); other counts, clears and
//   unused codes do not raise busy. Every byte adds to the total.
//   A query for rank r sweeps all bins once per rank position through the
//   single memory read port, r + 1 sweeps, and done follows the end of the
//   last sweep. When the rank lies beyond the distinct symbols, the first
//   sweep ends the search.
//   Reset (synchronous, active high) and the clear request empty the
//   histogram and the total at once through per-bin valid bits.
// ----------------------------------------------------------------------------
module symbol_frequency_sorted_ranking_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sfr_pkg::sfr_req_t request,
  output logic              busy,
  output logic              done,
  output sfr_pkg::sfr_rsp_t result
);
  import sfr_pkg::*;

  logic               accept;
  logic [COUNT_W-1:0] byte_total;
  sfr_mem_ctl_t       mem_ctl;
  logic [COUNT_W-1:0] wr_data;
  logic [COUNT_W-1:0] rd_data;
  sfr_rsp_t           seq_rsp;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total <= '0;
    end else if (accept) begin
      case (request.operation)
        OP_COUNT: byte_total <= sat_inc(byte_total);
        OP_CLEAR: byte_total <= '0;
        default:  byte_total <= byte_total;
      endcase
    end
  end

  sfr_bin_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  sfr_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .request (request),
    .rd_data (rd_data),
    .mem_ctl (mem_ctl),
    .wr_data (wr_data),
    .busy    (busy),
    .done    (done),
    .rsp     (seq_rsp)
  );

  always_comb begin
    result             = seq_rsp;
    result.total_bytes = byte_total;
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding search");

  a_found_weight: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (result.weight != '0) && (result.distinct_symbols != '0))
    else $error("found symbol has zero weight or no distinct symbols");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.symbol == '0) && (result.weight == '0))
    else $error("missed rank returns nonzero symbol or weight");

  a_count_rmw: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.operation == OP_COUNT) && (request.byte_value < 8'd127))
      |=> busy ##1 !busy)
    else $error("in-range count does not take exactly one busy cycle");

endmodule

// ===== rtl/sfr_bin_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin count memory
// One count per symbol with registered read data; a valid bit per entry
// makes never-written or cleared entries read as zero.
// ----------------------------------------------------------------------------
module sfr_bin_mem (
  input  logic                           clk,
  input  logic                           rst,
  input  sfr_pkg::sfr_mem_ctl_t          ctl,
  input  logic [sfr_pkg::COUNT_W-1:0]    wr_data,
  output logic [sfr_pkg::COUNT_W-1:0]    rd_data
);
  import sfr_pkg::*;

  logic [COUNT_W-1:0]  mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid;
  logic [COUNT_W-1:0]  rd_q;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid <= '0;
      end else if (ctl.wr_en) begin
        valid[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid <= valid[ctl.rd_addr] & ~ctl.clear;
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// ===== rtl/sfr_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ranking sequencer
// Runs the count read-modify-write and the rank search, which sweeps the
// bins once per rank position and keeps the smallest key above the last one.
// ----------------------------------------------------------------------------
module sfr_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  sfr_pkg::sfr_req_t             request,
  input  logic [sfr_pkg::COUNT_W-1:0]   rd_data,
  output sfr_pkg::sfr_mem_ctl_t         mem_ctl,
  output logic [sfr_pkg::COUNT_W-1:0]   wr_data,
  output logic                          busy,
  output logic                          done,
  output sfr_pkg::sfr_rsp_t             rsp
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_COUNT = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

  state_t             state;
  logic [BIN_W-1:0]   cnt_addr;
  logic [BIN_W-1:0]   scan_addr;
  logic               issuing;
  logic               rd_pend;
  logic [BIN_W-1:0]   rd_sym;
  logic [RANK_W-1:0]  rank;
  logic [RANK_W-1:0]  pass;
  logic [DIST_W-1:0]  distinct;
  logic [KEY_W-1:0]   prev_key;
  logic [KEY_W-1:0]   best_key;
  logic               best_ok;
  sfr_rsp_t           rsp_q;
  logic               done_q;

  logic               bin_hit;
  logic [KEY_W-1:0]   key;
  logic               nonzero;
  logic               cand;
  logic               best_ok_next;
  logic [KEY_W-1:0]   best_key_next;
  logic [DIST_W-1:0]  distinct_next;
  logic               last_bin;
  logic               finish;
  logic               found_next;

  assign bin_hit = (int'(request.byte_value) < NUM_BINS);

  // Shared compare unit: a key orders by weight, then by higher symbol first.
  assign key           = {rd_data, ~rd_sym};
  assign nonzero       = (rd_data != '0);
  assign cand          = rd_pend && nonzero && ((pass == '0) || (key > prev_key)) &&
                         (!best_ok || (key < best_key));
  assign best_ok_next  = best_ok | cand;
  assign best_key_next = cand ? key : best_key;
  assign distinct_next = (rd_pend && nonzero && (pass == '0)) ?
                         distinct + DIST_W'(1) : distinct;
  assign last_bin      = rd_pend && (rd_sym == LAST_BIN);
  assign finish        = last_bin && (!best_ok_next || (pass == rank) ||
                         ((pass == '0) && ({1'b0, rank} >= {1'b0, distinct_next})));
  assign found_next    = best_ok_next && (pass == rank);

  always_comb begin
    mem_ctl = '0;
    wr_data = sat_inc(rd_data);
    unique case (state)
      S_IDLE: begin
        if (accept && (request.operation == OP_COUNT) && bin_hit) begin
          mem_ctl.rd_en   = 1'b1;
          mem_ctl.rd_addr = request.byte_value[BIN_W-1:0];
        end
        mem_ctl.clear = accept && (request.operation == OP_CLEAR);
      end
      S_COUNT: begin
        mem_ctl.wr_en   = 1'b1;
        mem_ctl.wr_addr = cnt_addr;
      end
      S_SCAN: begin
        mem_ctl.rd_en   = issuing;
        mem_ctl.rd_addr = scan_addr;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issuing <= 1'b0;
      rd_pend <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (request.operation)
              OP_COUNT: begin
                if (bin_hit) begin
                  state    <= S_COUNT;
                  cnt_addr <= request.byte_value[BIN_W-1:0];
                end
              end
              OP_QUERY: begin
                state     <= S_SCAN;
                rank      <= request.rank_index;
                scan_addr <= '0;
                issuing   <= 1'b1;
                rd_pend   <= 1'b0;
                pass      <= '0;
                distinct  <= '0;
                best_ok   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_COUNT: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          rd_pend <= issuing;
          rd_sym  <= scan_addr;
          if (issuing) begin
            if (scan_addr == LAST_BIN) begin
              issuing <= 1'b0;
            end else begin
              scan_addr <= scan_addr + BIN_W'(1);
            end
          end
          best_ok  <= last_bin ? 1'b0 : best_ok_next;
          best_key <= best_key_next;
          distinct <= distinct_next;
          if (finish) begin
            state                  <= S_IDLE;
            done_q                 <= 1'b1;
            rsp_q.found            <= found_next;
            rsp_q.symbol           <= found_next ? 7'(~best_key_next[BIN_W-1:0]) : '0;
            rsp_q.weight           <= found_next ? best_key_next[KEY_W-1:BIN_W] : '0;
            rsp_q.distinct_symbols <= distinct_next;
            rsp_q.total_bytes      <= '0;
          end else if (last_bin) begin
            // Next position: restart the sweep above the key just found.
            prev_key  <= best_key_next;
            pass      <= pass + RANK_W'(1);
            scan_addr <= '0;
            issuing   <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = done_q;
  assign rsp  = rsp_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol frequency ranking testbench
// Drives count, query, clear and unused requests through the start/busy
// handshake and keeps its own histogram to work out each query answer that
// the directed table does not give. It starts with that table and a fill of
// every bin, then runs random bursts of counts over small alphabets followed
// by rank queries, in phases with and without gaps on the request side.
// ----------------------------------------------------------------------------
module tb_top;
  import sfr_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int ITEMS       = 1500;
  localparam int SWEEP       = 128;
  localparam int TAIL_CYCLES = 300;
  localparam sfr_rsp_t NO_ANSWER = '0;

  typedef struct {
    sfr_req_t req;
    bit       typed;
    sfr_rsp_t answer;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  sfr_req_t request = '0;
  logic     busy;
  logic     done;
  sfr_rsp_t result;

  // Histogram kept alongside the block.
  logic [COUNT_W-1:0] tally [NUM_BINS];
  logic [COUNT_W-1:0] bytes_seen;
  int                 live_symbols;

  sfr_rsp_t  pending_answers[$];
  plan_row_t plan[$];
  sfr_rsp_t  due;

  int     mismatches = 0;
  int     counted = 0;
  int     idle_pct = 0;
  longint cycle_count = 0;
  longint cycle_budget = 0;

  symbol_frequency_sorted_ranking_top uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Nonzero symbols in ascending weight; among equal weights the higher
  // symbol comes first, which falls out of inserting from the top symbol down.
  function automatic sfr_rsp_t rank_lookup(input logic [6:0] rank);
    int       order[$];
    int       pos;
    sfr_rsp_t ans;
    ans = '0;
    for (int s = NUM_BINS - 1; s >= 0; s--) begin
      if (tally[s] != '0) begin
        pos = 0;
        while (pos < order.size() && tally[order[pos]] <= tally[s]) pos++;
        order.insert(pos, s);
      end
    end
    ans.distinct_symbols = 7'(order.size());
    ans.total_bytes = bytes_seen;
    if (int'(rank) < order.size()) begin
      ans.found = 1'b1;
      ans.symbol = 7'(order[rank]);
      ans.weight = tally[order[rank]];
    end
    return ans;
  endfunction

  task automatic issue(input sfr_req_t req, input bit typed, input sfr_rsp_t answer);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do begin
        @(posedge clk);
        cycle_budget++;
      end while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (req.operation)
      OP_COUNT: begin
        cycle_budget += 8;
        if (req.byte_value < NUM_BINS) begin
          if (tally[req.byte_value[BIN_W-1:0]] == '0) live_symbols++;
          if (tally[req.byte_value[BIN_W-1:0]] != '1)
            tally[req.byte_value[BIN_W-1:0]] += 1'b1;
        end
        if (bytes_seen != '1) bytes_seen += 1'b1;
      end
      OP_CLEAR: begin
        cycle_budget += 8;
        foreach (tally[i]) tally[i] = '0;
        bytes_seen = '0;
        live_symbols = 0;
      end
      OP_QUERY: begin
        cycle_budget += SWEEP * (int'(req.rank_index) + 2) + 16;
        pending_answers.push_back(typed ? answer : rank_lookup(req.rank_index));
      end
      default: cycle_budget += 8;
    endcase
    if (req.operation != OP_SPARE) counted++;
  endtask

  task automatic send(input logic [1:0] op, input logic [7:0] b, input logic [6:0] r);
    sfr_req_t req;
    req.operation = op;
    req.byte_value = b;
    req.rank_index = r;
    issue(req, 1'b0, NO_ANSWER);
  endtask

  task automatic add_row(input logic [1:0] op, input logic [7:0] b, input logic [6:0] r,
                         input bit typed, input sfr_rsp_t answer);
    plan_row_t row;
    row.req.operation = op;
    row.req.byte_value = b;
    row.req.rank_index = r;
    row.typed = typed;
    row.answer = answer;
    plan.push_back(row);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result at cycle %0d: symbol=%0d weight=%0d",
                   cycle_count, result.symbol, result.weight);
        mismatches++;
      end else begin
        due = pending_answers.pop_front();
        if (result.found !== due.found || result.symbol !== due.symbol ||
            result.weight !== due.weight ||
            result.distinct_symbols !== due.distinct_symbols ||
            result.total_bytes !== due.total_bytes) begin
          if (mismatches < 10)
            $display({"mismatch at cycle %0d: expected found=%0d symbol=%0d weight=%0d ",
                      "distinct=%0d total=%0d, got found=%0d symbol=%0d weight=%0d ",
                      "distinct=%0d total=%0d"},
                     cycle_count, due.found, due.symbol, due.weight,
                     due.distinct_symbols, due.total_bytes, result.found, result.symbol,
                     result.weight, result.distinct_symbols, result.total_bytes);
          mismatches++;
        end
      end
    end
    if (cycle_count > 4 * cycle_budget + 50000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int         alphabet[6];
    int         alpha_n;
    int         roll;
    int         cap;
    int         offset;
    logic [7:0] b;
    logic [6:0] rank;

    foreach (tally[i]) tally[i] = '0;
    bytes_seen = '0;
    live_symbols = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_row(OP_QUERY, 8'h00, 7'd0,   1'b1, sfr_rsp_t'({1'b0, 7'd0, 32'd0, 7'd0, 32'd0}));
    add_row(OP_QUERY, 8'hFF, 7'd126, 1'b1, sfr_rsp_t'({1'b0, 7'd0, 32'd0, 7'd0, 32'd0}));
    add_row(OP_SPARE, 8'hAA, 7'h55,  1'b0, NO_ANSWER);
    // Bytes past the last bin only move the total.
    add_row(OP_COUNT, 8'hFF, 7'd0,   1'b0, NO_ANSWER);
    add_row(OP_COUNT, 8'd127, 7'd0,  1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd0,   1'b1, sfr_rsp_t'({1'b0, 7'd0, 32'd0, 7'd0, 32'd2}));
    add_row(OP_COUNT, 8'd126, 7'd0,  1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd0,   1'b1, sfr_rsp_t'({1'b1, 7'd126, 32'd1, 7'd1, 32'd3}));
    add_row(OP_COUNT, 8'd0,   7'd0,  1'b0, NO_ANSWER);
    add_row(OP_COUNT, 8'd126, 7'd0,  1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd0,   1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd1,   1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd2,   1'b0, NO_ANSWER);
    // Symbols 0 and 126 end up tied; the higher one must rank first.
    add_row(OP_COUNT, 8'd5,   7'd0,  1'b0, NO_ANSWER);
    add_row(OP_COUNT, 8'd0,   7'd0,  1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd1,   1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd2,   1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd126, 1'b0, NO_ANSWER);
    add_row(OP_SPARE, 8'h00, 7'd0,   1'b0, NO_ANSWER);
    add_row(OP_CLEAR, 8'h55, 7'h2A,  1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd0,   1'b1, sfr_rsp_t'({1'b0, 7'd0, 32'd0, 7'd0, 32'd0}));
    add_row(OP_COUNT, 8'h55, 7'd0,   1'b0, NO_ANSWER);
    add_row(OP_COUNT, 8'h2A, 7'd0,   1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd0,   1'b0, NO_ANSWER);
    add_row(OP_QUERY, 8'h00, 7'd1,   1'b0, NO_ANSWER);
    foreach (plan[i]) issue(plan[i].req, plan[i].typed, plan[i].answer);

    // Fill every bin once so that the deepest rank and a full distinct count occur.
    offset = $urandom_range(126);
    for (int s = 0; s < NUM_BINS; s++)
      send(OP_COUNT, 8'((s + offset) % NUM_BINS), 7'($urandom_range(126)));
    send(OP_QUERY, 8'($urandom), 7'd126);
    send(OP_QUERY, 8'($urandom), 7'd0);
    send(OP_QUERY, 8'($urandom), 7'($urandom_range(126)));
    send(OP_CLEAR, 8'($urandom), 7'($urandom_range(126)));

    // The receiver cannot stall, so the phases differ only in request gaps.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 74 : (phase == 3) ? 34 : 0;
      while (counted < ITEMS * (phase + 1) / 4) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          send(OP_SPARE, 8'($urandom), 7'($urandom_range(126)));
        end else if (roll < 8) begin
          send(OP_COUNT, 8'($urandom), 7'($urandom_range(126)));
        end else if (roll < 18) begin
          send(OP_CLEAR, 8'($urandom), 7'($urandom_range(126)));
        end else begin
          alpha_n = $urandom_range(6, 1);
          foreach (alphabet[i]) alphabet[i] = $urandom_range(126);
          repeat ($urandom_range(24, 1)) begin
            roll = $urandom_range(99);
            if (roll < 85) b = 8'(alphabet[$urandom_range(alpha_n - 1)]);
            else if (roll < 95) b = 8'($urandom_range(255));
            else b = 8'($urandom_range(255, 127));
            send(OP_COUNT, b, 7'($urandom_range(126)));
          end
          repeat ($urandom_range(3, 1)) begin
            roll = $urandom_range(99);
            cap = (live_symbols < 10) ? live_symbols + 1 : 10;
            if (roll < 70) rank = 7'($urandom_range(cap));
            else if (roll < 90) rank = 7'($urandom_range((live_symbols < 126) ? live_symbols : 126));
            else rank = 7'($urandom_range(126));
            send(OP_QUERY, 8'($urandom), rank);
          end
        end
      end
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sfr_pkg.sv
rtl/sfr_bin_mem.sv
rtl/sfr_seq.sv
rtl/symbol_frequency_sorted_ranking_top.sv
sim/tb_top.sv
